// ----- hw/rtl/etq_pkg.sv -----
package etq_pkg;

    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_FLUSH    = 2'd1;
    localparam logic [1:0] OP_STATUS   = 2'd2;
    localparam logic [1:0] OP_COMPLETE = 2'd3;

    localparam logic [3:0] KIND_PRIME   = 4'd0;
    localparam logic [3:0] KIND_APPEND  = 4'd1;
    localparam logic [3:0] KIND_EMPTY   = 4'd2;
    localparam logic [3:0] KIND_NOREG   = 4'd3;
    localparam logic [3:0] KIND_DONE    = 4'd4;
    localparam logic [3:0] KIND_ERROR   = 4'd5;
    localparam logic [3:0] KIND_NONE    = 4'd6;
    localparam logic [3:0] KIND_FLUSHED = 4'd7;
    localparam logic [3:0] KIND_STATUS  = 4'd8;

    localparam logic [3:0] FLAG_ACTIVE   = 4'h1;
    localparam logic [3:0] FLAG_ERR_MASK = 4'hE;

    localparam int MAX_RES = 8;

    // entries per queue; the entry fields are sized for this depth
    localparam int POOL_DEPTH = 8;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  entry;
        logic [2:0]  prev;
        logic [14:0] xfer;
        logic [31:0] tag;
        logic        notify;
    } res_t;

    function automatic res_t mk_res(logic [3:0] kind, logic [2:0] entry, logic [2:0] prev,
                                    logic [14:0] xfer, logic [31:0] tag, logic notify);
        res_t r;
        r.kind   = kind;
        r.entry  = entry;
        r.prev   = prev;
        r.xfer   = xfer;
        r.tag    = tag;
        r.notify = notify;
        return r;
    endfunction

endpackage

// ----- hw/rtl/etq_qstate_mem.sv -----
module etq_qstate_mem #(
    parameter int NQ        = 24,
    parameter int QW        = 5,
    parameter int EW        = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [NQ-1:0]   clr,
    input  logic [QW-1:0]   rd_addr,
    output logic [3*EW-1:0] rd_data,
    input  logic            we,
    input  logic [QW-1:0]   wr_addr,
    input  logic [3*EW-1:0] wr_data
);
    import etq_pkg::*;

    localparam logic [EW-1:0] NIL = EW'(POOL_DEPTH);

    logic [3*EW-1:0] mem [NQ];
    logic [3*EW-1:0] rd_mem_reg;
    logic            rd_valid_reg;
    logic [NQ-1:0]   valid_reg;
    logic [NQ-1:0]   valid_next;

    always_comb begin
        valid_next = valid_reg;
        for (int i = 0; i < NQ; i++) begin
            if (we && (int'(wr_addr) == i)) begin
                valid_next[i] = 1'b1;
            end
        end
        valid_next = valid_next & ~clr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_mem_reg   <= mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
    end

    // invalid queue reads as freshly initialized: free 0, head and tail null
    assign rd_data = rd_valid_reg ? rd_mem_reg : {EW'(0), NIL, NIL};

endmodule

// ----- hw/rtl/etq_entry_mem.sv -----
module etq_entry_mem #(
    parameter int NE = 192,
    parameter int AW = 8,
    parameter int EW = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [NE-1:0] clr,
    input  logic [AW-1:0] rd_addr,
    input  logic [EW-1:0] rd_local,
    output logic [EW-1:0] rd_link,
    output logic [14:0]   rd_len,
    output logic [14:0]   rd_rem,
    output logic [3:0]    rd_flags,
    output logic [31:0]   rd_tag,
    output logic          rd_notify,
    input  logic          link_we,
    input  logic [AW-1:0] link_addr,
    input  logic [EW-1:0] link_data,
    input  logic          sched_we,
    input  logic          stat_we,
    input  logic [AW-1:0] data_addr,
    input  logic [14:0]   wr_len,
    input  logic [31:0]   wr_tag,
    input  logic          wr_notify,
    input  logic [14:0]   wr_rem,
    input  logic [3:0]    wr_flags
);
    logic [EW-1:0] link_mem [NE];
    logic [14:0]   len_mem  [NE];
    logic [31:0]   tag_mem  [NE];
    logic          ntf_mem  [NE];
    logic [14:0]   rem_mem  [NE];
    logic [3:0]    flg_mem  [NE];

    logic [NE-1:0] valid_reg;
    logic [NE-1:0] valid_next;
    logic [EW-1:0] link_reg;
    logic          link_valid_reg;
    logic [EW-1:0] local_reg;

    always_comb begin
        valid_next = valid_reg;
        for (int i = 0; i < NE; i++) begin
            if (link_we && (int'(link_addr) == i)) begin
                valid_next[i] = 1'b1;
            end
        end
        valid_next = valid_next & ~clr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_addr] <= link_data;
        end
        if (sched_we) begin
            len_mem[data_addr] <= wr_len;
            tag_mem[data_addr] <= wr_tag;
            ntf_mem[data_addr] <= wr_notify;
        end
        if (sched_we || stat_we) begin
            rem_mem[data_addr] <= wr_rem;
            flg_mem[data_addr] <= wr_flags;
        end
        link_reg       <= link_mem[rd_addr];
        link_valid_reg <= valid_reg[rd_addr];
        local_reg      <= rd_local;
        rd_len         <= len_mem[rd_addr];
        rd_tag         <= tag_mem[rd_addr];
        rd_notify      <= ntf_mem[rd_addr];
        rd_rem         <= rem_mem[rd_addr];
        rd_flags       <= flg_mem[rd_addr];
    end

    // untouched link reads as the initial chain: entry i points to i+1
    assign rd_link = link_valid_reg ? link_reg : local_reg + EW'(1);

endmodule

// ----- hw/rtl/endpoint_transfer_queue.sv -----
// Channel  | Direction | Handshake            | Payload
// s_       | in        | s_valid / s_ready    | op, controller, endpoint, schedule, status fields
// m_       | out       | m_valid / m_ready    | kind, entry, prev tail, transferred, tag, notify, last
// cfg_     | in        | cfg_valid / cfg_ready| queue_registered bit mask
//
// One transaction at a time through a sequencer over the queue-state memory and the
// entry memory (one registered read port each).
// Flush and complete walk the active list; complete stops at a busy or bad entry.
// Each result waits on m_ready; the output register lets the walk run one result ahead.
// Reset clears the per-entry and per-queue valid bits directly, with no sweep.
module endpoint_transfer_queue #(
    parameter int QUEUES_PER_CONTROLLER = 12,
    parameter int NUM_CONTROLLERS       = 2
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             s_valid,
    output logic                                             s_ready,
    input  logic [1:0]                                       s_op,
    input  logic                                             s_controller,
    input  logic [7:0]                                       s_endpoint_address,
    input  logic [14:0]                                      s_max_length,
    input  logic                                             s_notify,
    input  logic [31:0]                                      s_user_tag,
    input  logic [2:0]                                       s_entry_index,
    input  logic [14:0]                                      s_remaining_bytes,
    input  logic [3:0]                                       s_status_flags,
    output logic                                             m_valid,
    input  logic                                             m_ready,
    output logic [3:0]                                       m_kind,
    output logic [2:0]                                       m_entry,
    output logic [2:0]                                       m_previous_tail,
    output logic [14:0]                                      m_transferred,
    output logic [31:0]                                      m_tag_out,
    output logic                                             m_notify_out,
    output logic                                             m_last,
    input  logic                                             cfg_valid,
    output logic                                             cfg_ready,
    input  logic [NUM_CONTROLLERS*QUEUES_PER_CONTROLLER-1:0] cfg_queue_registered
);
    import etq_pkg::*;

    localparam int NQ   = NUM_CONTROLLERS * QUEUES_PER_CONTROLLER;
    localparam int NE   = NQ * POOL_DEPTH;
    localparam int QW   = $clog2(NQ);
    localparam int AW   = $clog2(NE);
    localparam int EW   = $clog2(POOL_DEPTH + 1);
    localparam int CMAX = (POOL_DEPTH > MAX_RES) ? POOL_DEPTH : MAX_RES;
    localparam int CW   = $clog2(CMAX + 1);
    localparam logic [EW-1:0] NIL = EW'(POOL_DEPTH);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_QRD     = 4'd1;
    localparam logic [3:0] ST_SCH_RD  = 4'd2;
    localparam logic [3:0] ST_SCH_WR  = 4'd3;
    localparam logic [3:0] ST_SCH_APP = 4'd4;
    localparam logic [3:0] ST_FL_RD   = 4'd5;
    localparam logic [3:0] ST_FL_WB   = 4'd6;
    localparam logic [3:0] ST_CP_RD   = 4'd7;
    localparam logic [3:0] ST_CP_EV   = 4'd8;
    localparam logic [3:0] ST_FIN     = 4'd9;

    function automatic logic [AW-1:0] ent_addr(logic [QW-1:0] q, logic [EW-1:0] e);
        int a;
        a = int'(q) * POOL_DEPTH + int'(e);
        return AW'(a);
    endfunction

    logic [3:0]    state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic          known_reg, known_next;
    logic [QW-1:0] q_reg, q_next;
    logic [14:0]   len_reg, len_next;
    logic          ntf_reg, ntf_next;
    logic [31:0]   tag_reg, tag_next;
    logic [2:0]    idx_reg, idx_next;
    logic [14:0]   rem_reg, rem_next;
    logic [3:0]    sfl_reg, sfl_next;
    logic [EW-1:0] fh_reg, fh_next;
    logic [EW-1:0] ah_reg, ah_next;
    logic [EW-1:0] at_reg, at_next;
    logic [EW-1:0] prev_reg, prev_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    res_t          pend_reg, pend_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          qwe_reg, qwe_next;
    res_t          out_reg, out_next;
    logic          out_last_reg, out_last_next;
    logic          out_valid_reg, out_valid_next;
    logic [NQ-1:0] registered_reg, registered_next;

    logic            slot_free;
    logic            emit_en;
    res_t            emit_res;
    logic            emit_last;
    logic [4:0]      qi;
    logic [QW-1:0]   q_calc;
    logic            known_calc;
    logic [NQ-1:0]   cfg_clr;
    logic [NE-1:0]   ent_clr;

    logic [3*EW-1:0] qs_rd_data;
    logic            qs_we;
    logic [EW-1:0]   rd_local;
    logic [EW-1:0]   ent_link;
    logic [14:0]     ent_len;
    logic [14:0]     ent_rem;
    logic [3:0]      ent_flags;
    logic [31:0]     ent_tag;
    logic            ent_notify;
    logic            link_we;
    logic [AW-1:0]   link_addr;
    logic [EW-1:0]   link_data;
    logic            sched_we;
    logic            stat_we;
    logic [AW-1:0]   data_addr;
    logic [14:0]     wr_rem;
    logic [3:0]      wr_flags;

    assign qi = {s_endpoint_address[3:0], s_endpoint_address[7]};
    assign q_calc = QW'(int'(s_controller) * QUEUES_PER_CONTROLLER + int'(qi));
    assign known_calc = (int'(s_controller) < NUM_CONTROLLERS)
                     && (int'(qi) < QUEUES_PER_CONTROLLER)
                     && registered_reg[q_calc];

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || m_ready;

    // a queue whose bit rises starts over from its initial lists
    assign cfg_clr = (cfg_valid && cfg_ready) ? (cfg_queue_registered & ~registered_reg) : '0;

    for (genvar i = 0; i < NE; i++) begin : g_clr
        assign ent_clr[i] = cfg_clr[i / POOL_DEPTH];
    end

    assign rd_local = (state_reg == ST_SCH_RD) ? fh_reg : ah_reg;

    etq_qstate_mem #(
        .NQ(NQ), .QW(QW), .EW(EW)
    ) u_qstate (
        .aclk(aclk), .aresetn(aresetn), .clr(cfg_clr),
        .rd_addr(q_calc), .rd_data(qs_rd_data),
        .we(qs_we), .wr_addr(q_reg), .wr_data({fh_reg, ah_reg, at_reg})
    );

    etq_entry_mem #(
        .NE(NE), .AW(AW), .EW(EW)
    ) u_entry (
        .aclk(aclk), .aresetn(aresetn), .clr(ent_clr),
        .rd_addr(ent_addr(q_reg, rd_local)), .rd_local(rd_local),
        .rd_link(ent_link), .rd_len(ent_len), .rd_rem(ent_rem), .rd_flags(ent_flags),
        .rd_tag(ent_tag), .rd_notify(ent_notify),
        .link_we(link_we), .link_addr(link_addr), .link_data(link_data),
        .sched_we(sched_we), .stat_we(stat_we), .data_addr(data_addr),
        .wr_len(len_reg), .wr_tag(tag_reg), .wr_notify(ntf_reg),
        .wr_rem(wr_rem), .wr_flags(wr_flags)
    );

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        known_next      = known_reg;
        q_next          = q_reg;
        len_next        = len_reg;
        ntf_next        = ntf_reg;
        tag_next        = tag_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        sfl_next        = sfl_reg;
        fh_next         = fh_reg;
        ah_next         = ah_reg;
        at_next         = at_reg;
        prev_next       = prev_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        qwe_next        = qwe_reg;
        registered_next = registered_reg;
        emit_en         = 1'b0;
        emit_res        = pend_reg;
        emit_last       = 1'b0;
        qs_we           = 1'b0;
        link_we         = 1'b0;
        link_addr       = ent_addr(q_reg, ah_reg);
        link_data       = fh_reg;
        sched_we        = 1'b0;
        stat_we         = 1'b0;
        data_addr       = ent_addr(q_reg, fh_reg);
        wr_rem          = len_reg;
        wr_flags        = FLAG_ACTIVE;

        if (cfg_valid && cfg_ready) begin
            registered_next = cfg_queue_registered;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_op;
                    known_next = known_calc;
                    q_next     = q_calc;
                    len_next   = s_max_length;
                    ntf_next   = s_notify;
                    tag_next   = s_user_tag;
                    idx_next   = s_entry_index;
                    rem_next   = s_remaining_bytes;
                    sfl_next   = s_status_flags;
                    state_next = ST_QRD;
                end
            end
            ST_QRD: begin
                fh_next         = qs_rd_data[3*EW-1:2*EW];
                ah_next         = qs_rd_data[2*EW-1:EW];
                at_next         = qs_rd_data[EW-1:0];
                qwe_next        = 1'b1;
                pend_valid_next = 1'b0;
                cnt_next        = '0;
                if (!known_reg) begin
                    qwe_next   = 1'b0;
                    pend_next  = mk_res(KIND_NOREG, '0, '0, '0, '0, 1'b0);
                    state_next = ST_FIN;
                end else begin
                    case (op_reg)
                        OP_SCHEDULE: begin
                            if (qs_rd_data[3*EW-1:2*EW] == NIL) begin
                                pend_next  = mk_res(KIND_EMPTY, '0, '0, '0, '0, 1'b0);
                                state_next = ST_FIN;
                            end else begin
                                state_next = ST_SCH_RD;
                            end
                        end
                        OP_FLUSH: begin
                            state_next = ST_FL_RD;
                        end
                        OP_STATUS: begin
                            stat_we   = (int'(idx_reg) < POOL_DEPTH);
                            data_addr = ent_addr(q_reg, EW'(idx_reg));
                            wr_rem    = rem_reg;
                            wr_flags  = sfl_reg;
                            pend_next = mk_res(KIND_STATUS, '0, '0, '0, '0, 1'b0);
                            state_next = ST_FIN;
                        end
                        default: begin
                            state_next = ST_CP_RD;
                        end
                    endcase
                end
            end
            ST_SCH_RD: begin
                state_next = ST_SCH_WR;
            end
            ST_SCH_WR: begin
                fh_next   = ent_link;
                sched_we  = 1'b1;
                link_we   = 1'b1;
                link_addr = ent_addr(q_reg, fh_reg);
                link_data = NIL;
                at_next   = fh_reg;
                if (ah_reg == NIL) begin
                    ah_next    = fh_reg;
                    pend_next  = mk_res(KIND_PRIME, 3'(fh_reg), '0, '0, '0, 1'b0);
                    state_next = ST_FIN;
                end else begin
                    prev_next  = at_reg;
                    pend_next  = mk_res(KIND_APPEND, 3'(fh_reg), 3'(at_reg), '0, '0, 1'b0);
                    state_next = ST_SCH_APP;
                end
            end
            ST_SCH_APP: begin
                // chain the new entry after the old tail
                link_we    = (prev_reg != NIL);
                link_addr  = ent_addr(q_reg, prev_reg);
                link_data  = at_reg;
                state_next = ST_FIN;
            end
            ST_FL_RD: begin
                if (cnt_reg == CW'(POOL_DEPTH) || ah_reg == NIL) begin
                    ah_next    = NIL;
                    at_next    = NIL;
                    pend_next  = mk_res(KIND_FLUSHED, '0, '0, '0, '0, 1'b0);
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_FL_WB;
                end
            end
            ST_FL_WB: begin
                link_we    = 1'b1;
                fh_next    = ah_reg;
                ah_next    = ent_link;
                cnt_next   = cnt_reg + CW'(1);
                state_next = ST_FL_RD;
            end
            ST_CP_RD: begin
                if (cnt_reg == CW'(MAX_RES) || ah_reg == NIL) begin
                    if (!pend_valid_reg) begin
                        pend_next = mk_res(KIND_NONE, '0, '0, '0, '0, 1'b0);
                    end
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_CP_EV;
                end
            end
            ST_CP_EV: begin
                if ((ent_flags & FLAG_ERR_MASK) == 4'h0 && (ent_flags & FLAG_ACTIVE) != 4'h0) begin
                    if (!pend_valid_reg) begin
                        pend_next = mk_res(KIND_NONE, '0, '0, '0, '0, 1'b0);
                    end
                    state_next = ST_FIN;
                end else if (!pend_valid_reg || slot_free) begin
                    // release the held result; it is not the final one
                    emit_en   = pend_valid_reg;
                    emit_res  = pend_reg;
                    emit_last = 1'b0;
                    if ((ent_flags & FLAG_ERR_MASK) != 4'h0) begin
                        pend_next  = mk_res(KIND_ERROR, 3'(ah_reg), '0, '0, '0, 1'b0);
                        state_next = ST_FIN;
                    end else begin
                        pend_next       = mk_res(KIND_DONE, 3'(ah_reg), '0,
                                                 ent_len - ent_rem, ent_tag, ent_notify);
                        pend_valid_next = 1'b1;
                        link_we         = 1'b1;
                        fh_next         = ah_reg;
                        ah_next         = ent_link;
                        if (ent_link == NIL) begin
                            at_next = NIL;
                        end
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = ST_CP_RD;
                    end
                end
            end
            ST_FIN: begin
                if (slot_free) begin
                    emit_en    = 1'b1;
                    emit_res   = pend_reg;
                    emit_last  = 1'b1;
                    qs_we      = qwe_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        out_last_next  = out_last_reg;
        if (emit_en) begin
            out_valid_next = 1'b1;
            out_next       = emit_res;
            out_last_next  = emit_last;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            registered_reg <= '0;
            pend_valid_reg <= 1'b0;
            qwe_reg        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            registered_reg <= registered_next;
            pend_valid_reg <= pend_valid_next;
            qwe_reg        <= qwe_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        known_reg    <= known_next;
        q_reg        <= q_next;
        len_reg      <= len_next;
        ntf_reg      <= ntf_next;
        tag_reg      <= tag_next;
        idx_reg      <= idx_next;
        rem_reg      <= rem_next;
        sfl_reg      <= sfl_next;
        fh_reg       <= fh_next;
        ah_reg       <= ah_next;
        at_reg       <= at_next;
        prev_reg     <= prev_next;
        cnt_reg      <= cnt_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = out_reg.kind;
    assign m_entry         = out_reg.entry;
    assign m_previous_tail = out_reg.prev;
    assign m_transferred   = out_reg.xfer;
    assign m_tag_out       = out_reg.tag;
    assign m_notify_out    = out_reg.notify;
    assign m_last          = out_last_reg;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import etq_pkg::*;

    localparam int POOL   = 8;
    localparam int QPC    = 12;
    localparam int NQ     = 24;
    localparam logic [3:0] NIL = 4'd8;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [1:0]  op;
        logic        ctrl;
        logic [7:0]  addr;
        logic [14:0] max_len;
        logic        notify;
        logic [31:0] tag;
        logic [2:0]  eidx;
        logic [14:0] rem;
        logic [3:0]  flags;
    } xfer_req_t;

    typedef struct {
        res_t r;
        logic last;
    } expected_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_op = '0;
    logic s_controller = 1'b0;
    logic [7:0] s_endpoint_address = '0;
    logic [14:0] s_max_length = '0;
    logic s_notify = 1'b0;
    logic [31:0] s_user_tag = '0;
    logic [2:0] s_entry_index = '0;
    logic [14:0] s_remaining_bytes = '0;
    logic [3:0] s_status_flags = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [3:0] m_kind;
    logic [2:0] m_entry;
    logic [2:0] m_previous_tail;
    logic [14:0] m_transferred;
    logic [31:0] m_tag_out;
    logic m_notify_out;
    logic m_last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [23:0] cfg_queue_registered = '0;

    // Shadow copy of the descriptor bookkeeping
    logic [23:0] reg_mask;
    logic [3:0]  link_next [0:NQ*POOL-1];
    logic [3:0]  free_head [0:NQ-1];
    logic [3:0]  act_head  [0:NQ-1];
    logic [3:0]  act_tail  [0:NQ-1];
    logic [14:0] ent_len   [0:NQ*POOL-1];
    logic [14:0] ent_rem   [0:NQ*POOL-1];
    logic [3:0]  ent_flags [0:NQ*POOL-1];
    logic [31:0] ent_tag   [0:NQ*POOL-1];
    logic        ent_notify[0:NQ*POOL-1];

    expected_t pending_results[$];
    int fail_count = 0;
    int stall_cycles = 0;
    int hold_request = 0;
    bit idle_enable = 1'b1;

    always #5 aclk = ~aclk;

    endpoint_transfer_queue uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_controller(s_controller),
        .s_endpoint_address(s_endpoint_address), .s_max_length(s_max_length),
        .s_notify(s_notify), .s_user_tag(s_user_tag), .s_entry_index(s_entry_index),
        .s_remaining_bytes(s_remaining_bytes), .s_status_flags(s_status_flags),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind), .m_entry(m_entry),
        .m_previous_tail(m_previous_tail), .m_transferred(m_transferred),
        .m_tag_out(m_tag_out), .m_notify_out(m_notify_out), .m_last(m_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_queue_registered(cfg_queue_registered)
    );

    task automatic init_queue(int q);
        for (int i = 0; i < POOL; i++) link_next[q*POOL+i] = 4'(i + 1);
        free_head[q] = 4'd0;
        act_head[q] = NIL;
        act_tail[q] = NIL;
    endtask

    task automatic push_result(logic [3:0] kind, logic [2:0] entry, logic [2:0] prev,
                               logic [14:0] xfer, logic [31:0] tag, logic notify);
        expected_t x;
        x.r = mk_res(kind, entry, prev, xfer, tag, notify);
        x.last = 1'b0;
        pending_results.push_back(x);
    endtask

    task automatic predict_descriptors(xfer_req_t t);
        int qi, q, b, e, n, prev;
        qi = t.addr[3:0] * 2 + t.addr[7];
        n = 0;
        if (qi >= QPC || !reg_mask[t.ctrl*QPC + qi]) begin
            push_result(KIND_NOREG, 0, 0, 0, 0, 0);
            n = 1;
        end else begin
            q = t.ctrl * QPC + qi;
            b = q * POOL;
            case (t.op)
                OP_SCHEDULE: begin
                    e = free_head[q];
                    if (e >= POOL) begin
                        push_result(KIND_EMPTY, 0, 0, 0, 0, 0);
                    end else begin
                        free_head[q] = link_next[b+e];
                        ent_len[b+e] = t.max_len;
                        ent_rem[b+e] = t.max_len;
                        ent_flags[b+e] = FLAG_ACTIVE;
                        ent_notify[b+e] = t.notify;
                        ent_tag[b+e] = t.tag;
                        link_next[b+e] = NIL;
                        if (act_head[q] == NIL) begin
                            act_head[q] = 4'(e);
                            act_tail[q] = 4'(e);
                            push_result(KIND_PRIME, 3'(e), 0, 0, 0, 0);
                        end else begin
                            prev = act_tail[q];
                            if (prev < POOL) link_next[b+prev] = 4'(e);
                            act_tail[q] = 4'(e);
                            push_result(KIND_APPEND, 3'(e), 3'(prev), 0, 0, 0);
                        end
                    end
                    n = 1;
                end
                OP_FLUSH: begin
                    for (int g = 0; g < POOL && act_head[q] != NIL; g++) begin
                        e = act_head[q];
                        act_head[q] = link_next[b+e];
                        link_next[b+e] = free_head[q];
                        free_head[q] = 4'(e);
                    end
                    act_head[q] = NIL;
                    act_tail[q] = NIL;
                    push_result(KIND_FLUSHED, 0, 0, 0, 0, 0);
                    n = 1;
                end
                OP_STATUS: begin
                    ent_rem[b+t.eidx] = t.rem;
                    ent_flags[b+t.eidx] = t.flags;
                    push_result(KIND_STATUS, 0, 0, 0, 0, 0);
                    n = 1;
                end
                default: begin
                    while (n < MAX_RES && act_head[q] != NIL) begin
                        e = act_head[q];
                        if ((ent_flags[b+e] & FLAG_ERR_MASK) != 0) begin
                            push_result(KIND_ERROR, 3'(e), 0, 0, 0, 0);
                            n++;
                            break;
                        end
                        if (ent_flags[b+e][0]) break;
                        act_head[q] = link_next[b+e];
                        if (act_head[q] == NIL) act_tail[q] = NIL;
                        push_result(KIND_DONE, 3'(e), 0, ent_len[b+e] - ent_rem[b+e],
                                    ent_tag[b+e], ent_notify[b+e]);
                        link_next[b+e] = free_head[q];
                        free_head[q] = 4'(e);
                        n++;
                    end
                    if (n == 0) begin
                        push_result(KIND_NONE, 0, 0, 0, 0, 0);
                        n = 1;
                    end
                end
            endcase
        end
        pending_results[pending_results.size()-1].last = 1'b1;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(xfer_req_t t);
        if (idle_enable && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= t.op;
        s_controller <= t.ctrl;
        s_endpoint_address <= t.addr;
        s_max_length <= t.max_len;
        s_notify <= t.notify;
        s_user_tag <= t.tag;
        s_entry_index <= t.eidx;
        s_remaining_bytes <= t.rem;
        s_status_flags <= t.flags;
        do @(posedge aclk); while (!s_ready);
        predict_descriptors(t);
        @(negedge aclk);
    endtask

    task automatic write_registered(logic [23:0] mask);
        logic [23:0] old;
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_queue_registered <= mask;
        do @(posedge aclk); while (!cfg_ready);
        old = reg_mask;
        for (int q = 0; q < NQ; q++)
            if (mask[q] && !old[q]) init_queue(q);
        reg_mask = mask;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic xfer_req_t random_request();
        xfer_req_t t;
        t.op = 2'($urandom);
        t.ctrl = 1'($urandom);
        t.addr = 8'($urandom);
        t.max_len = 15'($urandom);
        t.notify = 1'($urandom);
        t.tag = $urandom;
        t.eidx = 3'($urandom);
        t.rem = 15'($urandom);
        t.flags = 4'($urandom);
        return t;
    endfunction

    function automatic xfer_req_t make_request(logic [1:0] op, logic ctrl, logic [7:0] addr);
        xfer_req_t t;
        t = random_request();
        t.op = op;
        t.ctrl = ctrl;
        t.addr = addr;
        return t;
    endfunction

    // Well-formed traffic on a queue among the low endpoint numbers, with some noise mixed in
    function automatic xfer_req_t shaped_request(int nqueues);
        xfer_req_t t;
        int nib, dir, q, pick, cnt, e;
        int walk [$];
        t = random_request();
        if ($urandom_range(99) < 10) return t;
        nib = $urandom_range(0, nqueues - 1);
        dir = $urandom_range(0, 1);
        t.addr = {1'(dir), 3'($urandom), 4'(nib)};
        q = t.ctrl * QPC + nib * 2 + dir;
        pick = $urandom_range(99);
        if (pick < 36) begin
            t.op = OP_SCHEDULE;
            if ($urandom_range(3) != 0) t.max_len = 15'($urandom_range(0, 4096));
        end else if (pick < 70) begin
            t.op = OP_STATUS;
            e = act_head[q];
            cnt = 0;
            while (e != NIL && cnt < POOL) begin
                walk.push_back(e);
                e = link_next[q*POOL+e];
                cnt++;
            end
            if (walk.size() != 0) t.eidx = 3'(walk[$urandom_range(0, walk.size()-1)]);
            cnt = $urandom_range(99);
            if (cnt < 70) t.flags = 4'd0;
            else if (cnt < 85) t.flags = FLAG_ACTIVE;
            if ($urandom_range(3) != 0) t.rem = 15'($urandom_range(0, 4096));
        end else if (pick < 94) begin
            t.op = OP_COMPLETE;
        end else begin
            t.op = OP_FLUSH;
        end
        return t;
    endfunction

    always @(negedge aclk) begin
        if (hold_request > 0) begin
            m_ready <= 1'b0;
            hold_request <= hold_request - 1;
        end else begin
            m_ready <= !(idle_enable && $urandom_range(99) < 9);
        end
    end

    always @(posedge aclk) begin
        expected_t x;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result kind=%0d", m_kind);
                fail_count++;
            end else begin
                x = pending_results.pop_front();
                if (m_kind !== x.r.kind) begin
                    $error("kind: expected %0d, got %0d", x.r.kind, m_kind);
                    fail_count++;
                end
                if (m_entry !== x.r.entry) begin
                    $error("entry: expected %0d, got %0d", x.r.entry, m_entry);
                    fail_count++;
                end
                if (m_previous_tail !== x.r.prev) begin
                    $error("previous_tail: expected %0d, got %0d", x.r.prev, m_previous_tail);
                    fail_count++;
                end
                if (m_transferred !== x.r.xfer) begin
                    $error("transferred: expected %0d, got %0d", x.r.xfer, m_transferred);
                    fail_count++;
                end
                if (m_tag_out !== x.r.tag) begin
                    $error("tag_out: expected %h, got %h", x.r.tag, m_tag_out);
                    fail_count++;
                end
                if (m_notify_out !== x.r.notify) begin
                    $error("notify_out: expected %0d, got %0d", x.r.notify, m_notify_out);
                    fail_count++;
                end
                if (m_last !== x.last) begin
                    $error("last: expected %0d, got %0d", x.last, m_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic test_unregistered();
        for (int op = 0; op < 4; op++)
            send_request(make_request(2'(op), 1'(op), 8'h00));
    endtask

    task automatic test_directed();
        xfer_req_t t;
        // Fill queue 0 past its pool with extreme fields
        t = make_request(OP_SCHEDULE, 1'b0, 8'h00);
        t.max_len = 15'h7FFF; t.tag = 32'hFFFF_FFFF; t.notify = 1'b1;
        send_request(t);
        t.max_len = 15'd0; t.tag = 32'd0; t.notify = 1'b0;
        send_request(t);
        for (int i = 0; i < 7; i++) send_request(make_request(OP_SCHEDULE, 1'b0, 8'h00));
        // Done, remaining above length, halted
        t = make_request(OP_STATUS, 1'b0, 8'h00);
        t.eidx = 3'd0; t.rem = 15'd0; t.flags = 4'd0;
        send_request(t);
        t.eidx = 3'd1; t.rem = 15'h7FFF;
        send_request(t);
        t.eidx = 3'd2; t.rem = 15'd5; t.flags = 4'h2;
        send_request(t);
        send_request(make_request(OP_COMPLETE, 1'b0, 8'h00));
        send_request(make_request(OP_COMPLETE, 1'b0, 8'h00));
        t.flags = FLAG_ACTIVE;
        send_request(t);
        send_request(make_request(OP_COMPLETE, 1'b0, 8'h00));
        send_request(make_request(OP_FLUSH, 1'b0, 8'h00));
        send_request(make_request(OP_COMPLETE, 1'b0, 8'h00));
        // Queue index past the end, and the highest valid one
        send_request(make_request(OP_SCHEDULE, 1'b1, 8'h86));
        send_request(make_request(OP_SCHEDULE, 1'b1, 8'hF5));
        // Eight finished entries in one complete
        for (int i = 0; i < 8; i++) send_request(make_request(OP_SCHEDULE, 1'b1, 8'h03));
        for (int i = 0; i < 8; i++) begin
            t = make_request(OP_STATUS, 1'b1, 8'h03);
            t.eidx = 3'(i); t.flags = 4'd0;
            send_request(t);
        end
        send_request(make_request(OP_COMPLETE, 1'b1, 8'h03));
    endtask

    task automatic test_random(int count, int nqueues);
        for (int i = 0; i < count; i++) send_request(shaped_request(nqueues));
    endtask

    task automatic test_backpressure();
        hold_request = 300;
        test_random(40, 2);
    endtask

    task automatic test_reconfigure();
        write_registered(24'($urandom));
        test_random(40, 6);
        write_registered(24'h000000);
        test_unregistered();
        write_registered(24'hFFFFFF);
        test_random(30, 3);
    endtask

    initial begin
        reg_mask = '0;
        for (int q = 0; q < NQ; q++) init_queue(q);
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_unregistered();
        write_registered(24'hFFFFFF);
        test_directed();
        test_random(120, 3);
        idle_enable = 1'b0;
        test_random(60, 6);
        idle_enable = 1'b1;
        test_backpressure();
        test_reconfigure();
        test_random(40, 2);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
